/* sv/kasm_pkg.sv */
// ---------------------------------------------------------------------------
// kasm_pkg: shared types and constants for the key autorepeat block
// Register indexes, configuration bundle and staged sample type.
// ---------------------------------------------------------------------------
package kasm_pkg;

  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVATION_PHASE   = 3'd4;

  // Reset value of the activation phase (start)
  localparam logic [PHASE_W-1:0] ACT_PHASE_RESET = 3'd1;

  typedef struct packed {
    logic               repeat_enable;
    logic [DELAY_W-1:0] repeat_period;
    logic               first_delay_enable;
    logic [DELAY_W-1:0] first_delay;
    logic [PHASE_W-1:0] activation_phase;
  } cfg_t;

  // One poll sample held in the input register
  typedef struct packed {
    logic              valid;
    logic              pressed;
    logic [TIME_W-1:0] now_ms;
  } stage_t;

endpackage

/* sv/kasm_if.sv */
// ---------------------------------------------------------------------------
// kasm_if: request channels of the key autorepeat block
// Sample channel (pressed, now_ms) and result channel (phase, active).
// ---------------------------------------------------------------------------
interface kasm_sample_if;
  logic                          valid;
  logic                          ready;
  logic                          pressed;
  logic [kasm_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, output pressed, output now_ms, input ready);
  modport sink   (input valid, input pressed, input now_ms, output ready);
endinterface

interface kasm_result_if;
  logic                          valid;
  logic                          ready;
  logic [kasm_pkg::PHASE_W-1:0]  phase;
  logic                          active;

  modport source (output valid, output phase, output active, input ready);
  modport sink   (input valid, input phase, input active, output ready);
endinterface

/* sv/kasm_cfg.sv */
// ---------------------------------------------------------------------------
// kasm_cfg: configuration registers
// Decodes the write port into the five typematic settings.
// ---------------------------------------------------------------------------
module kasm_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [kasm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kasm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output kasm_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_enable      <= 1'b0;
      cfg.repeat_period      <= '0;
      cfg.first_delay_enable <= 1'b0;
      cfg.first_delay        <= '0;
      cfg.activation_phase   <= kasm_pkg::ACT_PHASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kasm_pkg::REG_REPEAT_ENABLE:      cfg.repeat_enable      <= cfg_data[0];
        kasm_pkg::REG_REPEAT_PERIOD:      cfg.repeat_period      <= cfg_data;
        kasm_pkg::REG_FIRST_DELAY_ENABLE: cfg.first_delay_enable <= cfg_data[0];
        kasm_pkg::REG_FIRST_DELAY:        cfg.first_delay        <= cfg_data;
        kasm_pkg::REG_ACTIVATION_PHASE:
          cfg.activation_phase <= cfg_data[kasm_pkg::PHASE_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

endmodule

/* sv/kasm_stage.sv */
// ---------------------------------------------------------------------------
// kasm_stage: input register
// Captures one poll sample per cycle; advances when the next stage can take it.
// ---------------------------------------------------------------------------
module kasm_stage (
  input  logic              clk,
  input  logic              rst,
  kasm_sample_if.sink       sample,
  input  logic              take,     // downstream consumes the held sample
  output kasm_pkg::stage_t  stage
);

  assign sample.ready = !stage.valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (sample.ready) begin
      stage.valid <= sample.valid;
    end
    if (sample.ready && sample.valid) begin
      stage.pressed <= sample.pressed;
      stage.now_ms  <= sample.now_ms;
    end
  end

endmodule

/* sv/kasm_fsm.sv */
// ---------------------------------------------------------------------------
// kasm_fsm: typematic phase machine and result register
// Updates phase, mark time and first-repeat flag per sample.
// ---------------------------------------------------------------------------
module kasm_fsm (
  input  logic              clk,
  input  logic              rst,
  input  kasm_pkg::cfg_t    cfg,
  input  kasm_pkg::stage_t  stage,
  output logic              take,
  kasm_result_if.source     result
);

  typedef enum logic [kasm_pkg::PHASE_W-1:0] {
    PH_IDLE   = 3'd0,
    PH_START  = 3'd1,
    PH_HOLD   = 3'd2,
    PH_REPEAT = 3'd3,
    PH_END    = 3'd4
  } phase_t;

  phase_t                       phase;
  phase_t                       phase_next;
  logic [kasm_pkg::TIME_W-1:0]  mark_time;
  logic [kasm_pkg::TIME_W-1:0]  mark_time_next;
  logic                         rep_seen;
  logic                         rep_seen_next;
  logic [kasm_pkg::TIME_W-1:0]  elapsed;
  logic [kasm_pkg::DELAY_W-1:0] limit;
  logic                         use_first;
  logic                         fire;
  logic                         active_next;

  // Result register frees up when empty or being drained
  assign take = stage.valid && (!result.valid || result.ready);

  // Wrapping elapsed time and the delay in force
  assign elapsed   = stage.now_ms - mark_time;
  assign use_first = cfg.first_delay_enable && !rep_seen;
  assign limit     = use_first ? cfg.first_delay : cfg.repeat_period;
  assign fire      = cfg.repeat_enable &&
                     (elapsed > {{(kasm_pkg::TIME_W-kasm_pkg::DELAY_W){1'b0}}, limit});

  always_comb begin
    phase_next     = phase;
    mark_time_next = mark_time;
    rep_seen_next  = rep_seen;
    if (!stage.pressed) begin
      rep_seen_next = 1'b0;
      if (phase == PH_END) begin
        phase_next = PH_IDLE;
      end else if (phase != PH_IDLE) begin
        phase_next = PH_END;
      end
    end else begin
      unique case (phase)
        PH_IDLE, PH_END: begin
          phase_next     = PH_START;
          mark_time_next = stage.now_ms;
        end
        PH_START, PH_REPEAT: begin
          phase_next = PH_HOLD;
        end
        default: begin  // hold
          if (fire) begin
            phase_next     = PH_REPEAT;
            mark_time_next = stage.now_ms;
            rep_seen_next  = rep_seen || use_first;
          end
        end
      endcase
    end
  end

  assign active_next = (phase_next == phase_t'(cfg.activation_phase)) ||
                       (phase_next == PH_REPEAT);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      mark_time     <= '0;
      rep_seen      <= 1'b0;
      result.valid  <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        mark_time     <= mark_time_next;
        rep_seen      <= rep_seen_next;
        result.valid  <= 1'b1;
      end else if (result.ready) begin
        result.valid  <= 1'b0;
      end
    end
    if (take) begin
      result.phase  <= phase_next;
      result.active <= active_next;
    end
  end

endmodule

/* sv/key_autorepeat_state_machine.sv */
// ---------------------------------------------------------------------------
// key_autorepeat_state_machine: typematic autorepeat for one button
// Tracks idle/start/hold/repeat/end phases from poll samples.
// ---------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------
//  sample  | in  | valid/ready   | pressed (1), now_ms (32)
//  result  | out | valid/ready   | phase (3), active (1)
//  cfg     | in  | cfg_we only   | cfg_index (3), cfg_data (16)
//
// One request per cycle sustained while result is ready; a sample is held in
// the input register, then the phase update loads it into the result register,
// from which its result request is offered.
// The phase state updates as a sample enters the result register, so
// back-to-back samples see each other's updates.
// Reset: synchronous; phase idle, mark time and flag cleared, registers to
// their defaults, both registers empty.
// A stall on result holds the result register and backs up into the input
// register; sample.ready drops only when both are full.
// ---------------------------------------------------------------------------
module key_autorepeat_state_machine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [kasm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kasm_pkg::CFG_DATA_W-1:0]  cfg_data,
  kasm_sample_if.sink                      sample,
  kasm_result_if.source                    result
);

  kasm_pkg::cfg_t   cfg;    // live configuration
  kasm_pkg::stage_t stage;  // sample held in the input register
  logic             take;   // result side consumes the held sample

  kasm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kasm_stage u_stage (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .take   (take),
    .stage  (stage)
  );

  // Phase update and result register
  kasm_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .stage  (stage),
    .take   (take),
    .result (result)
  );

endmodule

/* tb/sv/key_autorepeat_state_machine_test.sv */
// ---------------------------------------------------------------------------
// key_autorepeat_state_machine_test: self-checking bench for key autorepeat
// Drives poll samples and register writes, tracks the typematic phase in a
// scoreboard and compares every result request field by field, in order.
// ---------------------------------------------------------------------------

typedef enum logic [2:0] {
  PH_IDLE   = 3'd0,
  PH_START  = 3'd1,
  PH_HOLD   = 3'd2,
  PH_REPEAT = 3'd3,
  PH_END    = 3'd4
} key_phase_t;

typedef struct packed {
  key_phase_t phase;
  logic       active;
} key_result_t;

// Tracks one button through its phases and queues the result of each sample
class typematic_board;
  logic        rep_en;
  logic [15:0] rep_period;
  logic        first_en;
  logic [15:0] first_dly;
  logic [2:0]  act_phase;

  key_phase_t  phase_now;
  logic [31:0] mark_ms;
  logic        repeated;

  key_result_t due_q[$];
  int unsigned checked;
  int unsigned failures;

  function new();
    rep_en     = 1'b0;
    rep_period = '0;
    first_en   = 1'b0;
    first_dly  = '0;
    act_phase  = kasm_pkg::ACT_PHASE_RESET;
    phase_now  = PH_IDLE;
    mark_ms    = '0;
    repeated   = 1'b0;
    checked    = 0;
    failures   = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      kasm_pkg::REG_REPEAT_ENABLE:      rep_en     = data[0];
      kasm_pkg::REG_REPEAT_PERIOD:      rep_period = data;
      kasm_pkg::REG_FIRST_DELAY_ENABLE: first_en   = data[0];
      kasm_pkg::REG_FIRST_DELAY:        first_dly  = data;
      kasm_pkg::REG_ACTIVATION_PHASE:   act_phase  = data[2:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return due_q.size();
  endfunction

  function void note_sample(logic pressed, logic [31:0] now_ms);
    logic [31:0] elapsed;
    logic        use_first;
    key_result_t res;
    if (!pressed) begin
      repeated = 1'b0;
      if (phase_now == PH_END)
        phase_now = PH_IDLE;
      else if (phase_now != PH_IDLE)
        phase_now = PH_END;
    end else begin
      case (phase_now)
        PH_IDLE, PH_END: begin
          phase_now = PH_START;
          mark_ms   = now_ms;
        end
        PH_START, PH_REPEAT: phase_now = PH_HOLD;
        default: begin
          if (rep_en) begin
            elapsed   = now_ms - mark_ms;
            use_first = first_en && !repeated;
            if (elapsed > {16'd0, (use_first ? first_dly : rep_period)}) begin
              phase_now = PH_REPEAT;
              mark_ms   = now_ms;
              if (use_first)
                repeated = 1'b1;
            end
          end
        end
      endcase
    end
    res.phase  = phase_now;
    res.active = (phase_now == act_phase) || (phase_now == PH_REPEAT);
    due_q.push_back(res);
  endfunction

  function void check_result(logic [2:0] phase, logic active);
    key_result_t want;
    checked++;
    if (due_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("result %0d with no request pending: phase %0d active %0b",
                 checked, phase, active);
      return;
    end
    want = due_q.pop_front();
    if (phase !== want.phase || active !== want.active) begin
      failures++;
      if (failures <= 10)
        $display("result %0d mismatch: want phase %0d active %0b, got phase %0d active %0b",
                 checked, want.phase, want.active, phase, active);
    end
  endfunction
endclass

module key_autorepeat_state_machine_test;

  localparam int unsigned HOLD_OFF_CYCLES = 300;

  logic                              clk;
  logic                              rst;
  logic                              cfg_we;
  logic [kasm_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [kasm_pkg::CFG_DATA_W-1:0]   cfg_data;

  kasm_sample_if samp_ch ();
  kasm_result_if res_ch ();

  key_autorepeat_state_machine uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (samp_ch.sink),
    .result    (res_ch.source)
  );

  typematic_board board = new();

  // Shared between the sender and the result sink
  bit          hold_off_req = 1'b0;   // sink parks ready low for a long stretch
  bit          no_gaps      = 1'b0;   // sender offers back to back
  int unsigned sent_count   = 0;
  logic [31:0] clock_ms     = '0;     // poll time, advanced per sample

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Generous ceiling: far above the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Idle gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Delay register values: mostly small so repeats show up, extremes too
  function automatic logic [15:0] pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 18) return 16'hFFFF;
    if (r < 25) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(1, 40));
  endfunction

  // Monitor: requests are taken at the rising edge on valid && ready
  always @(posedge clk) begin
    if (!rst) begin
      if (samp_ch.valid && samp_ch.ready)
        board.note_sample(samp_ch.pressed, samp_ch.now_ms);
      if (res_ch.valid && res_ch.ready)
        board.check_result(res_ch.phase, res_ch.active);
    end
  end

  // Result sink: runs of ready with random stalls, plus the long hold-off
  // on request so that both internal registers fill and sample.ready drops.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned run_left;
    res_ch.ready = 1'b0;
    stall_left   = 0;
    run_left     = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          stall_left = pick_gap();
          run_left   = $urandom_range(0, 60);
        end
      end
    end
  end

  task automatic config_write(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  task automatic apply_settings(input logic en, input logic [15:0] period,
                                input logic fen, input logic [15:0] fdly,
                                input logic [2:0] act);
    config_write(kasm_pkg::REG_REPEAT_ENABLE, {15'd0, en});
    config_write(kasm_pkg::REG_REPEAT_PERIOD, period);
    config_write(kasm_pkg::REG_FIRST_DELAY_ENABLE, {15'd0, fen});
    config_write(kasm_pkg::REG_FIRST_DELAY, fdly);
    config_write(kasm_pkg::REG_ACTIVATION_PHASE, {13'd0, act});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stop offering, drain everything, then let the two-stage
  // pipe settle
  task automatic wait_idle();
    @(negedge clk);
    samp_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_sample(input logic pressed, input logic [31:0] now_ms);
    int unsigned gap;
    @(negedge clk);
    samp_ch.valid   <= 1'b1;
    samp_ch.pressed <= pressed;
    samp_ch.now_ms  <= now_ms;
    do @(posedge clk); while (!samp_ch.ready);
    sent_count++;
    gap = no_gaps ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      samp_ch.valid <= 1'b0;
    end
  endtask

  // One keystroke: held samples then releases, time advancing by random
  // steps; a little noise on the level and rare jumps to any time value.
  task automatic press_run(input int unsigned n_held, input int unsigned n_rel,
                           input int unsigned max_step);
    logic lvl;
    for (int i = 0; i < n_held + n_rel; i++) begin
      lvl = (i < n_held);
      if ($urandom_range(0, 99) < 8)
        lvl = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 3)
        clock_ms = $urandom();
      else
        clock_ms += $urandom_range(0, max_step);
      send_sample(lvl, clock_ms);
    end
  endtask

  task automatic random_phase(input int unsigned n_items, input bit with_hold_off);
    logic        en;
    logic        fen;
    logic [15:0] per;
    logic [15:0] fdly;
    logic [2:0]  act;
    int unsigned max_step;
    int unsigned start_count;
    en   = ($urandom_range(0, 9) != 0);
    fen  = 1'($urandom_range(0, 1));
    per  = pick_delay();
    fdly = pick_delay();
    act  = 3'($urandom_range(0, 7));
    wait_idle();
    apply_settings(en, per, fen, fdly, act);
    // time steps scaled to the larger delay so repeats keep firing
    max_step    = ((per > fdly ? per : fdly) / 4) + 8;
    start_count = sent_count;
    if (with_hold_off) begin
      hold_off_req = 1'b1;
      no_gaps      = 1'b1;
      press_run(24, 2, max_step);
      no_gaps      = 1'b0;
    end
    while (sent_count - start_count < n_items)
      press_run($urandom_range(1, 30), $urandom_range(1, 3), max_step);
    press_run(0, 2, max_step);
  endtask

  initial begin : stimulus
    int unsigned drain;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    samp_ch.valid   = 1'b0;
    samp_ch.pressed = 1'b0;
    samp_ch.now_ms  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: repeat off, start counts as active.
    send_sample(1'b0, 32'hFFFF_FFFF);   // release while idle stays idle
    send_sample(1'b1, 32'h0000_0000);   // press -> start
    send_sample(1'b1, 32'hFFFF_FFFF);   // -> hold
    send_sample(1'b1, 32'h8000_0000);   // repeat off: stays hold
    send_sample(1'b0, 32'h0000_0005);   // -> end
    send_sample(1'b1, 32'h0000_0006);   // press from end -> start
    send_sample(1'b0, 32'h0000_0007);
    send_sample(1'b0, 32'h0000_0008);   // end -> idle

    // Zero period: fires on any elapsed time above zero, never on zero.
    wait_idle();
    apply_settings(1'b1, 16'h0000, 1'b0, 16'h0000, PH_HOLD);
    send_sample(1'b1, 32'd100);
    send_sample(1'b1, 32'd100);
    send_sample(1'b1, 32'd100);         // elapsed 0: no repeat
    send_sample(1'b1, 32'd101);         // repeat
    send_sample(1'b1, 32'd101);         // back to hold
    send_sample(1'b0, 32'd102);
    send_sample(1'b0, 32'd102);

    // Full-scale delays across the 32-bit wrap; activation value outside
    // the phase range, so only repeat reads as active.
    wait_idle();
    apply_settings(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 3'd7);
    send_sample(1'b1, 32'hFFFF_FF00);
    send_sample(1'b1, 32'hFFFF_FF00);
    send_sample(1'b1, 32'h0000_FEFF);   // elapsed exactly the delay: hold
    send_sample(1'b1, 32'h0000_FF00);   // one past: first repeat
    send_sample(1'b1, 32'h0000_FF00);
    send_sample(1'b1, 32'h0001_FEFF);   // steady period, equal: hold
    send_sample(1'b1, 32'h0001_FF00);   // repeat
    send_sample(1'b0, 32'h0001_FF01);
    send_sample(1'b0, 32'h0001_FF02);

    // Zero first delay then a short steady period; idle counts as active.
    wait_idle();
    apply_settings(1'b1, 16'd3, 1'b1, 16'h0000, PH_IDLE);
    send_sample(1'b1, 32'd10);
    send_sample(1'b1, 32'd10);
    send_sample(1'b1, 32'd11);          // first repeat, flag set
    send_sample(1'b1, 32'd11);
    send_sample(1'b1, 32'd14);          // period now applies: equal, hold
    send_sample(1'b1, 32'd15);          // repeat
    send_sample(1'b0, 32'd16);
    send_sample(1'b0, 32'd16);
    clock_ms = 32'd16;

    // Random keystrokes under several settings; one phase parks the sink.
    for (int p = 0; p < 6; p++)
      random_phase(60, p == 2);

    @(negedge clk);
    samp_ch.valid <= 1'b0;

    drain = 0;
    while (board.pending() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);

    if (board.failures == 0 && board.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* key_autorepeat_state_machine.f */
sv/kasm_pkg.sv
sv/kasm_if.sv
sv/kasm_cfg.sv
sv/kasm_stage.sv
sv/kasm_fsm.sv
sv/key_autorepeat_state_machine.sv
tb/sv/key_autorepeat_state_machine_test.sv
